// ===== rtl/core/mbd_pkg.sv =====
// Shared types and constants of the mipmap 2x2 box downsampler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mbd_pkg;

	// Fixed field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LANES    = 4;
	localparam int unsigned PSUM_W   = BYTE_W + 1;
	localparam int unsigned DIM_W    = 11;
	localparam int unsigned COLLAST_W = DIM_W + 1;
	localparam int unsigned IDX_W    = DIM_W - 1;
	localparam int unsigned BPP_W    = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = DIM_W;

	// Output height limit (fixed, not a parameter)
	localparam logic [DIM_W-1:0] MAX_OUT_HEIGHT = 11'd1024;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BPP        = 2'd2;

	// One pixel: four channel bytes, lane c at bits [8c+7:8c]
	typedef logic [LANES-1:0][BYTE_W-1:0] pix_t;

	// One line-buffer entry: four 9-bit horizontal pair sums
	typedef logic [LANES-1:0][PSUM_W-1:0] pair_t;

	// Decoded configuration handed to the datapath
	typedef struct packed {
		logic [COLLAST_W-1:0] col_last;
		logic [DIM_W-1:0]     row_last;
		logic [LANES-1:0]     ch_en;
	} cfg_t;

	// Scan position of the pixel now at the input
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             odd_col;
		logic             odd_row;
		logic             row_end;
		logic             last_row;
	} scan_t;

endpackage

`default_nettype wire

// ===== rtl/core/mbd_if.sv =====
// Channel interfaces of the mipmap 2x2 box downsampler: source pixels,
// averaged result pixels and configuration writes. Depends on mbd_pkg.
`default_nettype none

interface mbd_pix_if import mbd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_c0;
	logic [BYTE_W-1:0] in_c1;
	logic [BYTE_W-1:0] in_c2;
	logic [BYTE_W-1:0] in_c3;

	modport source (output valid, in_c0, in_c1, in_c2, in_c3, input ready);
	modport sink   (input valid, in_c0, in_c1, in_c2, in_c3, output ready);
endinterface

interface mbd_res_if import mbd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_c0;
	logic [BYTE_W-1:0] out_c1;
	logic [BYTE_W-1:0] out_c2;
	logic [BYTE_W-1:0] out_c3;
	logic              level_done;

	modport source (output valid, out_c0, out_c1, out_c2, out_c3, level_done,
		input ready);
	modport sink   (input valid, out_c0, out_c1, out_c2, out_c3, level_done,
		output ready);
endinterface

interface mbd_cfg_if import mbd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mbd_cfg_regs.sv =====
// Configuration registers of the downsampler and their clamped decode.
// Depends on mbd_pkg and mbd_cfg_if.
`default_nettype none

module mbd_cfg_regs import mbd_pkg::*; #(
	parameter int unsigned MAX_OUT_WIDTH = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mbd_cfg_if.sink   cfg,
	output cfg_t      cfg_dec
);

	// Width limit as it fits the 11-bit register
	localparam logic [DIM_W-1:0] WIDTH_LIM =
		(MAX_OUT_WIDTH > 2047) ? 11'd2047 : DIM_W'(MAX_OUT_WIDTH);

	logic [DIM_W-1:0] out_width_q;
	logic [DIM_W-1:0] out_height_q;
	logic [BPP_W-1:0] bpp_q;
	logic             wr;
	logic [DIM_W-1:0] w_clamp;
	logic [DIM_W-1:0] h_clamp;
	logic [BPP_W-1:0] nch;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_width_q  <= 11'd1;
			out_height_q <= 11'd1;
			bpp_q        <= 3'd4;
		end else if (wr) begin
			unique case (cfg.index)
				REG_OUT_WIDTH:  out_width_q  <= cfg.data;
				REG_OUT_HEIGHT: out_height_q <= cfg.data;
				REG_BPP:        bpp_q        <= cfg.data[BPP_W-1:0];
				default:        ;
			endcase
		end
	end

	// Clamp dimensions to [1, limit] and channel count to 4
	always_comb begin
		if (out_width_q == '0)
			w_clamp = 11'd1;
		else if (out_width_q > WIDTH_LIM)
			w_clamp = WIDTH_LIM;
		else
			w_clamp = out_width_q;

		if (out_height_q == '0)
			h_clamp = 11'd1;
		else if (out_height_q > MAX_OUT_HEIGHT)
			h_clamp = MAX_OUT_HEIGHT;
		else
			h_clamp = out_height_q;

		nch = (bpp_q > 3'd4) ? 3'd4 : bpp_q;

		cfg_dec.col_last = {w_clamp, 1'b0} - 12'd1;
		cfg_dec.row_last = {h_clamp[DIM_W-2:0], 1'b0} - 11'd1;
		for (int c = 0; c < LANES; c++)
			cfg_dec.ch_en[c] = (BPP_W'(c) < nch);
	end

endmodule

`default_nettype wire

// ===== rtl/core/mbd_scan.sv =====
// Source column and row counters of the downsampler raster scan.
// Depends on mbd_pkg.
`default_nettype none

module mbd_scan import mbd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  cfg_t      cfg_dec,
	output scan_t     pos
);

	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;

	// Position decode; ends are taken as reached or passed
	always_comb begin
		pos.idx      = col_q[DIM_W-1:1];
		pos.odd_col  = col_q[0];
		pos.odd_row  = row_q[0];
		pos.row_end  = {1'b0, col_q} >= cfg_dec.col_last;
		pos.last_row = row_q >= cfg_dec.row_last;
	end

	// Advance one pixel per accepted word, wrap at row and level end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (pos.row_end) begin
				col_q <= '0;
				row_q <= pos.last_row ? '0 : row_q + 11'd1;
			end else begin
				col_q <= col_q + 11'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mbd_line_buf.sv =====
// Line buffer of horizontal pair sums: one write or one read per cycle,
// registered read data. Depends on mbd_pkg.
`default_nettype none

module mbd_line_buf import mbd_pkg::*; #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          wr,
	input  wire logic          rd,
	input  wire logic [AW-1:0] addr,
	input  pair_t              wdata,
	output pair_t              rdata
);

	pair_t mem [DEPTH];
	pair_t rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr)
			mem[addr] <= wdata;
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd)
			rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/mipmap_box_downsample.sv =====
// Top level of the mipmap 2x2 box downsampler: scan counters, line buffer
// and result pipeline. Depends on mbd_pkg, mbd_if, mbd_cfg_regs, mbd_scan
// and mbd_line_buf.
//
//   channel  dir  word
//   src      in   one source pixel, in_c0..in_c3, raster order
//   dst      out  one averaged pixel, out_c0..out_c3, level_done
//   cfg      in   register write: index, data (always ready)
//
// Sustained rate is one source pixel per cycle while dst does not stall;
// the line buffer sees one access per horizontal pixel pair. A result is
// registered on dst after its bottom-right source pixel is accepted (line
// read at the accept edge, then sum into the output reg as stage 1 moves).
// Reset clears counters, held pixel and valids; line entries are undefined
// until the even row writes them, so there is no clearing pass.
// A stalled dst holds its word; src.ready drops only while a finished block
// waits in stage 1 behind a held output word.
`default_nettype none

module mipmap_box_downsample import mbd_pkg::*; #(
	parameter int unsigned MAX_OUT_WIDTH = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mbd_pix_if.sink   src,
	mbd_res_if.source dst,
	mbd_cfg_if.sink   cfg
);

	localparam int unsigned AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

	cfg_t             cfg_dec;
	scan_t            pos;
	logic             src_acc;
	logic             in_range;
	logic             lb_wr;
	logic             lb_rd;
	logic [AW+IDX_W-1:0] idx_ext;
	logic [AW-1:0]    lb_addr;
	pix_t             px_raw;
	pix_t             px;
	pix_t             held_q;
	pair_t            pair_now;
	pair_t            lb_rdata;
	logic             s1_valid;
	logic             s1_move;
	pair_t            pair_s1;
	logic             done_s1;
	pix_t             avg;
	logic             out_valid_q;
	pix_t             out_pix_q;
	logic             out_done_q;

	mbd_cfg_regs #(.MAX_OUT_WIDTH(MAX_OUT_WIDTH)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_dec (cfg_dec)
	);

	mbd_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (src_acc),
		.cfg_dec (cfg_dec),
		.pos     (pos)
	);

	mbd_line_buf #(.DEPTH(MAX_OUT_WIDTH), .AW(AW)) u_line (
		.clk   (clk),
		.wr    (lb_wr),
		.rd    (lb_rd),
		.addr  (lb_addr),
		.wdata (pair_now),
		.rdata (lb_rdata)
	);

	// Handshake: stage 1 only holds words that produce a result
	assign s1_move   = s1_valid && (!out_valid_q || dst.ready);
	assign src.ready = !s1_valid || s1_move;
	assign src_acc   = src.valid && src.ready;

	// Channel masking of the incoming word
	always_comb begin
		px_raw = {src.in_c3, src.in_c2, src.in_c1, src.in_c0};
		for (int c = 0; c < LANES; c++)
			px[c] = cfg_dec.ch_en[c] ? px_raw[c] : '0;
	end

	// Horizontal pair sum of held left pixel and current right pixel
	always_comb begin
		for (int c = 0; c < LANES; c++)
			pair_now[c] = {1'b0, held_q[c]} + {1'b0, px[c]};
	end

	// Line access: even rows write pair sums, odd rows read them back.
	// A write and the read of the same entry are always a row apart.
	assign in_range = 32'(pos.idx) < MAX_OUT_WIDTH;
	assign lb_wr    = src_acc && pos.odd_col && in_range && !pos.odd_row;
	assign lb_rd    = src_acc && pos.odd_col && in_range && pos.odd_row;
	assign idx_ext  = {{AW{1'b0}}, pos.idx};
	assign lb_addr  = idx_ext[AW-1:0];

	// Left pixel of the current pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			held_q <= '0;
		else if (src_acc && !pos.odd_col)
			held_q <= px;
	end

	// Stage 1: bottom pair sum waits for the line read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (lb_rd)
			s1_valid <= 1'b1;
		else if (s1_move)
			s1_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (lb_rd) begin
			pair_s1 <= pair_now;
			done_s1 <= pos.row_end && pos.last_row;
		end
	end

	// Four-byte sum, truncated divide by four
	always_comb begin
		logic [PSUM_W:0] sum;
		for (int c = 0; c < LANES; c++) begin
			sum    = {1'b0, lb_rdata[c]} + {1'b0, pair_s1[c]};
			avg[c] = sum[PSUM_W:2];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_move)
			out_valid_q <= 1'b1;
		else if (dst.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_pix_q  <= avg;
			out_done_q <= done_s1;
		end
	end

	assign dst.valid      = out_valid_q;
	assign dst.out_c0     = out_pix_q[0];
	assign dst.out_c1     = out_pix_q[1];
	assign dst.out_c2     = out_pix_q[2];
	assign dst.out_c3     = out_pix_q[3];
	assign dst.level_done = out_done_q;

	// Checks
	a_no_accept_behind_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_move) |-> !src_acc)
		else $error("source word taken while stage 1 is stalled");

	a_single_line_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(lb_wr && lb_rd))
		else $error("line buffer read and write in one cycle");

	a_move_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> out_valid_q)
		else $error("stage 1 word lost on its way to the output register");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_move) |=> (s1_valid && $stable(pair_s1) && $stable(lb_rdata)))
		else $error("stalled stage 1 word changed");

endmodule

`default_nettype wire
